// ----- hdl/md5_message_digest_defines.svh -----
// assertion helpers
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MD5_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

// ----- hdl/md5_pkg.sv -----
package md5_pkg;
	localparam int FifoDepth = 4;
	localparam logic [31:0] InitA = 32'h67452301;
	localparam logic [31:0] InitB = 32'hefcdab89;
	localparam logic [31:0] InitC = 32'h98badcfe;
	localparam logic [31:0] InitD = 32'h10325476;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       fin;
	} item_t;

	function automatic logic [31:0] kconst(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
			32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
			32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
			32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
			32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
			32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
		return k[r];
	endfunction

	function automatic logic [4:0] rot(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
			4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
			4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
			4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction
endpackage

// ----- hdl/md5_front.sv -----
// input queue: holds words until the core takes them
module md5_front #(
	parameter int Depth = md5_pkg::FifoDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  md5_pkg::item_t in_item,
	output logic          avail,
	input  logic          take,
	output md5_pkg::item_t out_item
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	md5_pkg::item_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(Depth));
	assign avail    = (cnt_q != '0);
	assign out_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (take && avail)
				rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(take && avail);
		end
	end
endmodule

// ----- hdl/md5_core.sv -----
// byte packing, padding, one round per cycle, digest output register
module md5_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           avail,
	output logic           take,
	input  md5_pkg::item_t item,
	output logic           empty,
	input  logic           pop,
	output logic [31:0]    digest_word,
	output logic [1:0]     word_index,
	output logic           last_word
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_RUN, ST_OUT
	} state_t;

	state_t        state_q, ret_q;
	logic [31:0]   buf_q [16];
	logic [31:0]   h_q [4];
	logic [31:0]   a_q, b_q, c_q, d_q;
	logic [63:0]   len_q;
	logic [5:0]    pos_q, rnd_q;
	logic [2:0]    lcnt_q;
	logic          fin_q;
	logic [1:0]    oidx_q;

	logic [31:0] f, t, tr;
	logic [3:0]  widx;
	logic [5:0]  r2;

	assign take        = (state_q == ST_IDLE) && avail;
	assign empty       = (state_q != ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 2'd3);

	always_comb begin
		r2 = rnd_q;
		unique case (rnd_q[5:4])
			2'd0: begin f = (b_q & c_q) | (~b_q & d_q); widx = rnd_q[3:0]; end
			2'd1: begin f = (b_q & d_q) | (c_q & ~d_q); r2 = 6'(rnd_q * 5 + 1); widx = r2[3:0]; end
			2'd2: begin f = b_q ^ c_q ^ d_q; r2 = 6'(rnd_q * 3 + 5); widx = r2[3:0]; end
			default: begin f = c_q ^ (b_q | ~d_q); r2 = 6'(rnd_q * 7); widx = r2[3:0]; end
		endcase
		t  = a_q + f + buf_q[widx] + md5_pkg::kconst(rnd_q);
		tr = (t << md5_pkg::rot(rnd_q)) | (t >> (6'd32 - {1'b0, md5_pkg::rot(rnd_q)}));
	end

	// byte into a block word; the state machine starts compression when the block fills
	function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] sel,
		input logic [7:0] v);
		logic [31:0] r;
		r = w;
		r[sel*8 +: 8] = v;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && avail && item.has)
			buf_q[pos_q[5:2]] <= put(buf_q[pos_q[5:2]], pos_q[1:0], item.data);
		else if (state_q == ST_PAD)
			buf_q[pos_q[5:2]] <= put(buf_q[pos_q[5:2]], pos_q[1:0], fin_q ? 8'h00 : 8'h80);
		else if (state_q == ST_LEN)
			buf_q[pos_q[5:2]] <= put(buf_q[pos_q[5:2]], pos_q[1:0], len_q[lcnt_q*8 +: 8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; ret_q <= ST_IDLE;
			h_q <= '{md5_pkg::InitA, md5_pkg::InitB, md5_pkg::InitC, md5_pkg::InitD};
			len_q <= '0; pos_q <= '0; rnd_q <= '0; lcnt_q <= '0; fin_q <= 1'b0;
			oidx_q <= '0; a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (avail) begin
					// fin_q marks that 0x80 is already placed
					fin_q <= 1'b0;
					if (item.has) begin
						len_q <= len_q + 64'd8;
						pos_q <= pos_q + 1'b1;
					end
					if (item.has && pos_q == 6'd63) begin
						{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
						rnd_q <= '0;
						state_q <= ST_RUN;
						ret_q <= item.fin ? ST_PAD : ST_IDLE;
					end else if (item.fin)
						state_q <= ST_PAD;
				end
				ST_PAD: begin
					fin_q <= 1'b1;
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd55) begin
						lcnt_q <= '0;
						state_q <= ST_LEN;
					end else if (pos_q == 6'd63) begin
						{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
						rnd_q <= '0;
						state_q <= ST_RUN;
						ret_q <= ST_PAD;
					end
				end
				ST_LEN: begin
					pos_q <= pos_q + 1'b1;
					lcnt_q <= lcnt_q + 1'b1;
					if (lcnt_q == 3'd7) begin
						{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
						rnd_q <= '0;
						state_q <= ST_RUN;
						ret_q <= ST_OUT;
					end
				end
				ST_RUN: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + tr;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						h_q[0] <= h_q[0] + d_q;
						h_q[1] <= h_q[1] + b_q + tr;
						h_q[2] <= h_q[2] + b_q;
						h_q[3] <= h_q[3] + c_q;
						state_q <= ret_q;
						oidx_q <= '0;
					end
				end
				ST_OUT: if (pop) begin
					oidx_q <= oidx_q + 1'b1;
					if (oidx_q == 2'd3) begin
						h_q <= '{md5_pkg::InitA, md5_pkg::InitB, md5_pkg::InitC, md5_pkg::InitD};
						len_q <= '0; pos_q <= '0; fin_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/md5_message_digest.sv -----
// channel | handshake    | words
// in      | push / full  | data_byte, has_byte, msg_end
// out     | empty / pop  | digest_word, word_index, last_word
// The core takes one byte at a time; a full block then runs through the round unit.
// A message end adds padding, one pad byte at a time, and one or two compressions.
// The digest leaves as four words, one per pop; input queues in a 4-deep buffer meanwhile.
// Reset returns the chaining words and counters to their initial values.
module md5_message_digest #(
	parameter int FifoDepth = md5_pkg::FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        msg_end,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	md5_pkg::item_t in_item, q_item;
	logic avail, take;

	assign in_item = '{data: data_byte, has: has_byte, fin: msg_end};

	md5_front #(.Depth(FifoDepth)) u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.avail, .take, .out_item(q_item)
	);

	md5_core u_core (
		.clk, .arst_n, .avail, .take, .item(q_item),
		.empty, .pop, .digest_word, .word_index, .last_word
	);
endmodule

// ----- hdl/md5_checker.sv -----
`include "md5_message_digest_defines.svh"
module md5_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  word_index,
	input logic        last_word
);
	`MD5_ASSERT(a_last, clk, arst_n, last_word == (word_index == 2'd3), "last_word mismatch")
	`MD5_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop,
		!empty && $stable(word_index), "word dropped")
	`MD5_ASSERT_NEXT(a_step, clk, arst_n, !empty && pop && !last_word,
		!empty && word_index == $past(word_index) + 2'd1, "index skip")
	`MD5_ASSERT_NEXT(a_first, clk, arst_n, empty, empty || word_index == 2'd0, "digest not at word 0")
endmodule

bind md5_message_digest md5_checker u_chk (
	.clk, .arst_n, .empty, .pop, .word_index, .last_word
);

// ----- sim/md5_message_digest_checker.sv -----
module md5_message_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        msg_end,
	input  logic        empty,
	input  logic        pop,
	input  logic [31:0] digest_word,
	input  logic [1:0]  word_index,
	input  logic        last_word,
	output int          errors,
	output int          pending,
	output int          digests_seen
);
	typedef struct {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_word_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
		32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
		32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
		32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
		32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
		32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
	localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	logic [31:0] chain [4];
	logic [31:0] blk [16];
	logic [63:0] nbits;
	logic [5:0]  fill;
	digest_word_t digest_q [$];

	function automatic logic [31:0] rotl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] a, b, c, d, f, t;
		int g, w;
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int r = 0; r < 64; r++) begin
			g = r / 16;
			case (g)
				0: begin f = (b & c) | (~b & d); w = r % 16; end
				1: begin f = (b & d) | (c & ~d); w = (5 * r + 1) % 16; end
				2: begin f = b ^ c ^ d; w = (3 * r + 5) % 16; end
				default: begin f = c ^ (b | ~d); w = (7 * r) % 16; end
			endcase
			t = a + f + blk[w] + ROUND_K[r];
			a = d; d = c; c = b;
			b = b + rotl(t, SHIFTS[g * 4 + r % 4]);
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endtask

	task automatic absorb(logic [7:0] v);
		blk[fill[5:2]][fill[1:0] * 8 +: 8] = v;
		fill = fill + 6'd1;
		if (fill == 0)
			compress();
	endtask

	task automatic restart();
		chain[0] = md5_pkg::InitA; chain[1] = md5_pkg::InitB;
		chain[2] = md5_pkg::InitC; chain[3] = md5_pkg::InitD;
		nbits = '0;
		fill = '0;
		foreach (blk[i]) blk[i] = '0;
	endtask

	task automatic take_item(logic [7:0] v, logic has, logic fin);
		logic [63:0] len;
		if (has) begin
			absorb(v);
			nbits += 64'd8;
		end
		if (fin) begin
			len = nbits;
			absorb(8'h80);
			while (fill != 6'd56)
				absorb(8'h00);
			for (int k = 0; k < 8; k++)
				absorb(len[8 * k +: 8]);
			for (int k = 0; k < 4; k++)
				digest_q.push_back('{chain[k], 2'(k), k == 3});
			restart();
		end
	endtask

	initial begin
		errors = 0;
		digests_seen = 0;
		restart();
	end

	assign pending = digest_q.size();

	always @(posedge clk) begin
		digest_word_t e;
		if (arst_n) begin
			if (push && !full)
				take_item(data_byte, has_byte, msg_end);
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected word %h idx %0d", $time, digest_word, word_index);
					errors++;
				end else begin
					e = digest_q.pop_front();
					if (e.word !== digest_word || e.idx !== word_index || e.last !== last_word) begin
						$display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
							e.word, e.idx, e.last, digest_word, word_index, last_word);
						errors++;
					end
					if (e.last)
						digests_seen++;
				end
			end
		end
	end
endmodule

// ----- sim/md5_message_digest_test.sv -----
module md5_message_digest_test;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic [7:0]  data_byte = 0;
	logic        has_byte = 0;
	logic        msg_end = 0;
	logic        pop = 0;
	logic        full, empty, last_word;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	int          errors, pending, digests_seen;
	int          cycles = 0;
	int          words_sent = 0;

	localparam int CYCLE_LIMIT = 600000;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	md5_message_digest dut (.*);

	md5_message_digest_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: stall pattern of its own, with stretches of steady pops
	always @(posedge clk) begin
		if (cycles % 400 < 100)
			pop <= 1'b1;
		else
			pop <= ($urandom_range(0, 3) != 0);
	end

	task automatic send(logic [7:0] v, logic has, logic fin);
		push <= 1'b1;
		data_byte <= v;
		has_byte <= has;
		msg_end <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_message(int len, bit ending_byte);
		for (int i = 0; i < len; i++) begin
			send(8'($urandom_range(0, 255)), 1'b1, ending_byte && i == len - 1);
			idle_gap();
		end
		if (!ending_byte || len == 0)
			send(8'($urandom), 1'b0, 1'b1);
		idle_gap();
	endtask

	initial begin
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// empty message, null words, bytes at extremes
		send(8'h5a, 1'b0, 1'b0);
		send(8'hff, 1'b0, 1'b1);
		send(8'h00, 1'b1, 1'b0);
		send(8'hff, 1'b1, 1'b1);
		send(8'h61, 1'b1, 1'b0);
		send(8'h62, 1'b1, 1'b0);
		send(8'h63, 1'b1, 1'b1);
		send(8'h00, 1'b0, 1'b0);
		send(8'haa, 1'b0, 1'b1);
		push <= 1'b0;
		// hold off until every digest word is out
		while (pending != 0)
			@(posedge clk);
		// padding spills past the block end, second compression for the length
		send_message(60, 1);
		// random short messages
		while (words_sent < 120) begin
			len = $urandom_range(0, 12);
			send_message(len, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0)
				send(8'($urandom), 1'b0, 1'b0);
		end
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("sent %0d words, checked %0d digests incl. empty message and padding spill",
			words_sent, digests_seen);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
